### src/hall_six_step_commutator_macros.svh
// assertion macros for the commutator, checked on aclk with reset held off
`ifndef HALL_SIX_STEP_COMMUTATOR_MACROS_SVH
`define HALL_SIX_STEP_COMMUTATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define HSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hsc assertion failed");
`define HSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hsc assertion failed");
`else
`define HSC_ASSERT_IMPL(lbl, ante, cons)
`define HSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/hsc_pkg.sv
package hsc_pkg;

    localparam logic       FUNC_TICK    = 1'b0;
    localparam logic       FUNC_CMD     = 1'b1;

    localparam logic [1:0] PHASE_NONE   = 2'd0;
    localparam logic [1:0] PHASE_U      = 2'd1;
    localparam logic [1:0] PHASE_V      = 2'd2;
    localparam logic [1:0] PHASE_W      = 2'd3;

    localparam logic [1:0] SDIR_NONE    = 2'd0;
    localparam logic [1:0] SDIR_CW      = 2'd1;
    localparam logic [1:0] SDIR_CCW     = 2'd2;

    localparam logic [3:0] HALL_NONE    = 4'hF;
    localparam logic [7:0] WINDOW_RESET = 8'd100;
    localparam logic [2:0] STEP_MIRROR  = 3'd7;
    localparam logic [2:0] STEP_MAX     = 3'd6;

    localparam logic [7:0] CW_PAIRS  [6] = '{8'h62, 8'h23, 8'h31, 8'h15, 8'h54, 8'h46};
    localparam logic [7:0] CCW_PAIRS [6] = '{8'h45, 8'h51, 8'h13, 8'h32, 8'h26, 8'h64};

    localparam logic       REG_SPEED_WINDOW = 1'b0;

    typedef struct packed {
        logic        func;
        logic [2:0]  hall_state;
        logic        direction;
        logic [15:0] duty;
    } item_t;

    typedef struct packed {
        logic [15:0]        hold_ticks;
        logic signed [31:0] speed;
        logic signed [31:0] position;
        logic [1:0]         step_direction;
        logic               hall_fault;
        logic               running;
        logic [15:0]        pwm_compare;
        logic [1:0]         low_side_phase;
        logic [1:0]         high_side_phase;
    } result_t;

    function automatic logic [2:0] step_of(input logic [2:0] hall, input logic cw);
        return cw ? 3'(STEP_MIRROR - hall) : hall;
    endfunction

    function automatic logic step_valid(input logic [2:0] step);
        return (step != 3'd0) && (step != STEP_MIRROR);
    endfunction

    function automatic logic [1:0] phase_hi(input logic [2:0] step);
        logic [1:0] p;
        unique case (step)
            3'd1:    p = PHASE_U;
            3'd2:    p = PHASE_V;
            3'd3:    p = PHASE_V;
            3'd4:    p = PHASE_W;
            3'd5:    p = PHASE_U;
            3'd6:    p = PHASE_W;
            default: p = PHASE_NONE;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] phase_lo(input logic [2:0] step);
        logic [1:0] p;
        unique case (step)
            3'd1:    p = PHASE_W;
            3'd2:    p = PHASE_U;
            3'd3:    p = PHASE_W;
            3'd4:    p = PHASE_V;
            3'd5:    p = PHASE_V;
            3'd6:    p = PHASE_U;
            default: p = PHASE_NONE;
        endcase
        return p;
    endfunction

    // ccw table wins when a pair were in both
    function automatic logic [1:0] classify(input logic [2:0] from, input logic [2:0] to);
        logic [7:0] key;
        logic       hit_cw;
        logic       hit_ccw;
        key     = {1'b0, from, 1'b0, to};
        hit_cw  = 1'b0;
        hit_ccw = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (key == CW_PAIRS[i])  hit_cw  = 1'b1;
            if (key == CCW_PAIRS[i]) hit_ccw = 1'b1;
        end
        if (from > STEP_MAX || to > STEP_MAX) return SDIR_NONE;
        if (hit_ccw) return SDIR_CCW;
        if (hit_cw)  return SDIR_CW;
        return SDIR_NONE;
    endfunction

endpackage

### src/hsc_cfg.sv
module hsc_cfg
    import hsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  speed_window
);

    logic [7:0] speed_window_reg;
    logic       wr_en;

    // word decode, byte offset bits ignored
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SPEED_WINDOW);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_window_reg <= WINDOW_RESET;
        end else if (wr_en) begin
            speed_window_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_SPEED_WINDOW) begin
            prdata = {24'd0, speed_window_reg};
        end
    end

    assign speed_window = speed_window_reg;

endmodule

### src/hsc_core.sv
module hsc_core
    import hsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  item_t      item,
    input  logic [7:0] speed_window,
    output result_t    result
);

    logic               run_flag_reg,     run_flag_next;
    logic               dir_cw_reg,       dir_cw_next;
    logic [15:0]        duty_reg,         duty_next;
    logic [3:0]         prev_hall_reg,    prev_hall_next;
    logic [2:0]         cur_step_reg,     cur_step_next;
    logic [2:0]         prev_step_reg,    prev_step_next;
    logic [1:0]         drive_high_reg,   drive_high_next;
    logic [1:0]         drive_low_reg,    drive_low_next;
    logic signed [31:0] pos_count_reg,    pos_count_next;
    logic signed [31:0] pos_sampled_reg,  pos_sampled_next;
    logic signed [31:0] speed_reg,        speed_next;
    logic [7:0]         window_count_reg, window_count_next;
    logic [15:0]        hold_count_reg,   hold_count_next;

    logic [7:0] wc_inc;
    logic [2:0] step_new;
    logic [1:0] sdir;
    logic       fault;

    always_comb begin
        run_flag_next     = run_flag_reg;
        dir_cw_next       = dir_cw_reg;
        duty_next         = duty_reg;
        prev_hall_next    = prev_hall_reg;
        cur_step_next     = cur_step_reg;
        prev_step_next    = prev_step_reg;
        drive_high_next   = drive_high_reg;
        drive_low_next    = drive_low_reg;
        pos_count_next    = pos_count_reg;
        pos_sampled_next  = pos_sampled_reg;
        speed_next        = speed_reg;
        window_count_next = window_count_reg;
        hold_count_next   = hold_count_reg;
        wc_inc            = window_count_reg + 8'd1;
        step_new          = cur_step_reg;
        sdir              = SDIR_NONE;
        fault             = 1'b0;

        if (item.func == FUNC_TICK) begin
            if (wc_inc == speed_window) begin
                speed_next        = pos_count_reg - pos_sampled_reg;
                pos_sampled_next  = pos_count_reg;
                window_count_next = 8'd0;
            end else begin
                window_count_next = wc_inc;
            end
            if (run_flag_reg) begin
                if ({1'b0, item.hall_state} != prev_hall_reg) begin
                    step_new        = step_of(item.hall_state, dir_cw_reg);
                    cur_step_next   = step_new;
                    prev_hall_next  = {1'b0, item.hall_state};
                    drive_high_next = phase_hi(step_new);
                    drive_low_next  = phase_lo(step_new);
                    if (!step_valid(step_new)) begin
                        run_flag_next = 1'b0;
                        fault         = 1'b1;
                    end
                end
                if (prev_step_reg != step_new) begin
                    hold_count_next = 16'd0;
                    sdir            = classify(prev_step_reg, step_new);
                    if (sdir == SDIR_CCW) begin
                        pos_count_next = pos_count_reg - 32'sd1;
                    end else if (sdir == SDIR_CW) begin
                        pos_count_next = pos_count_reg + 32'sd1;
                    end
                    prev_step_next = step_new;
                end else if (run_flag_next && hold_count_reg != 16'hFFFF) begin
                    hold_count_next = hold_count_reg + 16'd1;
                end
            end
        end else begin
            dir_cw_next = item.direction;
            if (item.duty == 16'd0) begin
                drive_high_next = PHASE_NONE;
                drive_low_next  = PHASE_NONE;
                duty_next       = 16'd0;
                run_flag_next   = 1'b0;
            end else begin
                duty_next       = item.duty;
                step_new        = step_of(item.hall_state, item.direction);
                cur_step_next   = step_new;
                drive_high_next = phase_hi(step_new);
                drive_low_next  = phase_lo(step_new);
                run_flag_next   = step_valid(step_new);
                fault           = !step_valid(step_new);
            end
        end
    end

    always_comb begin
        result.high_side_phase = drive_high_next;
        result.low_side_phase  = drive_low_next;
        result.pwm_compare     = (drive_high_next != PHASE_NONE) ? duty_next : 16'd0;
        result.running         = run_flag_next;
        result.hall_fault      = fault;
        result.step_direction  = sdir;
        result.position        = pos_count_next;
        result.speed           = speed_next;
        result.hold_ticks      = hold_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_flag_reg     <= 1'b0;
            dir_cw_reg       <= 1'b0;
            duty_reg         <= 16'd0;
            prev_hall_reg    <= HALL_NONE;
            cur_step_reg     <= 3'd0;
            prev_step_reg    <= 3'd0;
            drive_high_reg   <= PHASE_NONE;
            drive_low_reg    <= PHASE_NONE;
            pos_count_reg    <= 32'sd0;
            pos_sampled_reg  <= 32'sd0;
            speed_reg        <= 32'sd0;
            window_count_reg <= 8'd0;
            hold_count_reg   <= 16'd0;
        end else if (fire) begin
            run_flag_reg     <= run_flag_next;
            dir_cw_reg       <= dir_cw_next;
            duty_reg         <= duty_next;
            prev_hall_reg    <= prev_hall_next;
            cur_step_reg     <= cur_step_next;
            prev_step_reg    <= prev_step_next;
            drive_high_reg   <= drive_high_next;
            drive_low_reg    <= drive_low_next;
            pos_count_reg    <= pos_count_next;
            pos_sampled_reg  <= pos_sampled_next;
            speed_reg        <= speed_next;
            window_count_reg <= window_count_next;
            hold_count_reg   <= hold_count_next;
        end
    end

endmodule

### src/hall_six_step_commutator.sv
// channel   dir   handshake            payload
// s_        in    s_tvalid/s_tready    tick or run command with hall pins
// m_        out   m_tvalid/m_tready    drive phases, flags, position, speed, hold
// cfg       in    apb, pready high     speed_window at byte address 0
//
// one word per cycle sustained while m_tready is high; a taken word is held in the input register,
// updates the state and is put on m_ by the result register
// reset: synchronous, aresetn low; no words held, speed_window back to 100
// m_tready low holds the result; the input register still takes one more word,
// then s_tready drops until the result is taken
`include "hall_six_step_commutator_macros.svh"

module hall_six_step_commutator
    import hsc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hall_state[2:0], direction[3], duty[19:4], zero[23:20]
    input  logic [23:0]  s_tdata,
    // func[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // high_side_phase[1:0], low_side_phase[3:2], pwm_compare[19:4], running[20],
    // hall_fault[21], step_direction[23:22], position[55:24], speed[87:56],
    // hold_ticks[103:88]
    output logic [103:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    item_t      in_reg;
    logic       in_valid_reg;
    result_t    out_reg;
    logic       out_valid_reg;
    result_t    core_result;
    logic       advance;
    logic [7:0] speed_window;

    hsc_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .speed_window (speed_window)
    );

    hsc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .item         (in_reg),
        .speed_window (speed_window),
        .result       (core_result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.func       <= s_tuser;
            in_reg.hall_state <= s_tdata[2:0];
            in_reg.direction  <= s_tdata[3];
            in_reg.duty       <= s_tdata[19:4];
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `HSC_ASSERT_IMPL(a_fault_stops, out_valid_reg && out_reg.hall_fault, !out_reg.running)
    `HSC_ASSERT_IMPL(a_fault_drive_off, out_valid_reg && out_reg.hall_fault,
        out_reg.high_side_phase == PHASE_NONE && out_reg.low_side_phase == PHASE_NONE)
    `HSC_ASSERT_IMPL(a_pwm_needs_high, out_valid_reg && out_reg.pwm_compare != 16'd0,
        out_reg.high_side_phase != PHASE_NONE)
    `HSC_ASSERT_NEXT(a_step_resets_hold, advance && core_result.step_direction != SDIR_NONE,
        out_reg.hold_ticks == 16'd0)

endmodule

### bench/tb_hall_six_step_commutator.sv
module tb_hall_six_step_commutator;
    import hsc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    // phase pairs per step, steps 0 and 7 drive nothing
    localparam logic [1:0] HI_OF_STEP [8] = '{PHASE_NONE, PHASE_U, PHASE_V, PHASE_V,
                                              PHASE_W, PHASE_U, PHASE_W, PHASE_NONE};
    localparam logic [1:0] LO_OF_STEP [8] = '{PHASE_NONE, PHASE_W, PHASE_U, PHASE_W,
                                              PHASE_V, PHASE_V, PHASE_U, PHASE_NONE};
    // step order of a counter-clockwise turn
    localparam logic [2:0] CCW_ORDER [6] = '{3'd4, 3'd5, 3'd1, 3'd3, 3'd2, 3'd6};

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    hall_six_step_commutator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // motor state as the block should hold it
    logic [7:0]  win_len = WINDOW_RESET;
    logic [7:0]  win_cnt = '0;
    logic        spin = 1'b0;
    logic        rev_cw = 1'b0;
    logic [15:0] duty_q = '0;
    logic [3:0]  last_hall = HALL_NONE;
    logic [2:0]  step_now = '0;
    logic [2:0]  step_old = '0;
    logic [1:0]  hi_ph = PHASE_NONE;
    logic [1:0]  lo_ph = PHASE_NONE;
    logic [31:0] pos = '0;
    logic [31:0] pos_mark = '0;
    logic [31:0] spd = '0;
    logic [15:0] held = '0;

    item_t   pending_words[$];
    result_t due_results[$];
    int      queued_cnt = 0;
    int      done_cnt = 0;
    int      errors = 0;
    int      cycles = 0;
    logic    took = 1'b0;
    logic    idle_on = 1'b1;
    int      send_gap = 0;
    int      stall_gap = 0;

    // word generator state: step index in the turn, hall mapping and turn sense
    logic    g_cw = 1'b0;
    logic    g_rot = 1'b0;
    int      g_idx = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= 100)
            $display("mismatch at result %0d, %s: got %0h, want %0h", done_cnt, what, got, want);
    endtask

    function automatic logic commute(input logic [2:0] hall);
        step_now = rev_cw ? 3'(STEP_MIRROR - hall) : hall;
        hi_ph = HI_OF_STEP[step_now];
        lo_ph = LO_OF_STEP[step_now];
        if (step_now != 3'd0 && step_now != STEP_MIRROR)
            return 1'b0;
        spin = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [1:0] transition(input logic [2:0] from, input logic [2:0] to);
        logic [7:0] key;
        logic [1:0] sd;
        key = {1'b0, from, 1'b0, to};
        sd = SDIR_NONE;
        if (from == STEP_MIRROR || to == STEP_MIRROR)
            return SDIR_NONE;
        for (int i = 0; i < 6; i++) begin
            if (key == CW_PAIRS[i] && sd == SDIR_NONE) sd = SDIR_CW;
            if (key == CCW_PAIRS[i]) sd = SDIR_CCW;
        end
        return sd;
    endfunction

    function automatic result_t advance(input item_t it);
        result_t    r;
        logic       fault;
        logic       was_on;
        logic [1:0] sd;
        fault = 1'b0;
        sd = SDIR_NONE;
        if (it.func == FUNC_TICK) begin
            win_cnt = win_cnt + 8'd1;
            if (win_cnt == win_len) begin
                spd = pos - pos_mark;
                pos_mark = pos;
                win_cnt = '0;
            end
            was_on = spin;
            if (was_on) begin
                if ({1'b0, it.hall_state} != last_hall) begin
                    fault = commute(it.hall_state);
                    last_hall = {1'b0, it.hall_state};
                end
                if (step_old != step_now) begin
                    held = '0;
                    sd = transition(step_old, step_now);
                    if (sd == SDIR_CCW)
                        pos = pos - 32'd1;
                    else if (sd == SDIR_CW)
                        pos = pos + 32'd1;
                    step_old = step_now;
                end else if (spin && held != 16'hFFFF) begin
                    held = held + 16'd1;
                end
            end
        end else begin
            rev_cw = it.direction;
            if (it.duty == 16'd0) begin
                hi_ph = PHASE_NONE;
                lo_ph = PHASE_NONE;
                duty_q = '0;
                spin = 1'b0;
            end else begin
                duty_q = it.duty;
                spin = 1'b1;
                fault = commute(it.hall_state);
            end
        end
        r.high_side_phase = hi_ph;
        r.low_side_phase  = lo_ph;
        r.pwm_compare     = (hi_ph != PHASE_NONE) ? duty_q : 16'd0;
        r.running         = spin;
        r.hall_fault      = fault;
        r.step_direction  = sd;
        r.position        = pos;
        r.speed           = spd;
        r.hold_ticks      = held;
        return r;
    endfunction

    // monitor: config writes, accepted words and results, all at the rising edge
    always @(posedge aclk) begin
        item_t   seen;
        result_t got;
        result_t want;
        took <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (psel && penable && pwrite && pready)
                win_len = pwdata[7:0];
            if (psel && penable && !pwrite && prdata !== {24'd0, win_len})
                report("speed_window readback", prdata, {24'd0, win_len});
            if (s_tvalid && s_tready) begin
                seen.func       = s_tuser;
                seen.hall_state = s_tdata[2:0];
                seen.direction  = s_tdata[3];
                seen.duty       = s_tdata[19:4];
                due_results.push_back(advance(seen));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (due_results.size() == 0) begin
                    report("result with nothing due", 32'd0, 32'd0);
                end else begin
                    want = due_results.pop_front();
                    if (got.high_side_phase !== want.high_side_phase)
                        report("high_side_phase", got.high_side_phase, want.high_side_phase);
                    if (got.low_side_phase !== want.low_side_phase)
                        report("low_side_phase", got.low_side_phase, want.low_side_phase);
                    if (got.pwm_compare !== want.pwm_compare)
                        report("pwm_compare", got.pwm_compare, want.pwm_compare);
                    if (got.running !== want.running)
                        report("running", got.running, want.running);
                    if (got.hall_fault !== want.hall_fault)
                        report("hall_fault", got.hall_fault, want.hall_fault);
                    if (got.step_direction !== want.step_direction)
                        report("step_direction", got.step_direction, want.step_direction);
                    if (got.position !== want.position)
                        report("position", got.position, want.position);
                    if (got.speed !== want.speed)
                        report("speed", got.speed, want.speed);
                    if (got.hold_ticks !== want.hold_ticks)
                        report("hold_ticks", got.hold_ticks, want.hold_ticks);
                    done_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** hall_six_step_commutator: FAILED **");
            $finish;
        end
    end

    // driver: offers the next word once the last one is taken, with random gaps
    always @(negedge aclk) begin
        item_t pkt;
        logic  nv;
        if (aresetn && !(s_tvalid && !took)) begin
            nv = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
            end else if (pending_words.size() != 0) begin
                pkt = pending_words.pop_front();
                s_tdata <= {4'd0, pkt.duty, pkt.direction, pkt.hall_state};
                s_tuser <= pkt.func;
                nv = 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            s_tvalid <= nv;
        end
        if (stall_gap != 0) begin
            stall_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 6) == 0)
                stall_gap = $urandom_range(1, 19);
        end
    end

    task automatic push(input logic f, input logic [2:0] h, input logic d, input logic [15:0] du);
        item_t it;
        it.func       = f;
        it.hall_state = h;
        it.direction  = d;
        it.duty       = du;
        pending_words.push_back(it);
        queued_cnt++;
    endtask

    function automatic logic [2:0] hall_of(input int idx);
        return g_cw ? 3'(STEP_MIRROR - CCW_ORDER[idx]) : CCW_ORDER[idx];
    endfunction

    function automatic logic [15:0] pick_duty();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 16'hFFFF;
        if (r == 1) return 16'h0001;
        return 16'($urandom_range(1, 65535));
    endfunction

    task automatic tick(input logic [2:0] h);
        push(FUNC_TICK, h, 1'($urandom_range(0, 1)), 16'($urandom));
    endtask

    task automatic spin_up;
        g_cw = 1'($urandom_range(0, 1));
        g_rot = 1'($urandom_range(0, 1));
        g_idx = $urandom_range(0, 5);
        push(FUNC_CMD, hall_of(g_idx), g_cw, pick_duty());
    endtask

    task automatic step_on;
        g_idx = g_rot ? (g_idx + 1) % 6 : (g_idx + 5) % 6;
        tick(hall_of(g_idx));
    endtask

    // mostly clean turns with holds, reversals, skips, faults, stops and noise
    task automatic random_run(input int n);
        int r;
        spin_up();
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                step_on();
            end else if (r < 70) begin
                tick(hall_of(g_idx));
            end else if (r < 75) begin
                g_rot = ~g_rot;
                step_on();
            end else if (r < 80) begin
                // skipped step, not a table transition
                g_idx = (g_idx + $urandom_range(2, 4)) % 6;
                tick(hall_of(g_idx));
            end else if (r < 85) begin
                g_cw = 1'($urandom_range(0, 1));
                push(FUNC_CMD, hall_of(g_idx), g_cw, pick_duty());
            end else if (r < 88) begin
                push(FUNC_CMD, 3'($urandom), 1'($urandom_range(0, 1)), 16'd0);
                tick(3'($urandom));
                spin_up();
            end else if (r < 91) begin
                tick($urandom_range(0, 1) ? 3'd7 : 3'd0);
                spin_up();
            end else if (r < 95) begin
                push(1'($urandom_range(0, 1)), 3'($urandom), 1'($urandom_range(0, 1)),
                     16'($urandom));
                spin_up();
            end else begin
                push(FUNC_CMD, hall_of(g_idx), g_cw, pick_duty());
            end
        end
    endtask

    task automatic drain;
        do @(negedge aclk); while (done_cnt != queued_cnt);
    endtask

    task automatic apb_access(input logic wr, input logic [7:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_SPEED_WINDOW, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_window(input logic [7:0] val);
        drain();
        apb_access(1'b1, val);
        apb_access(1'b0, 8'd0);
        idle_on = ($urandom_range(0, 3) != 0);
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset window, clean turns both ways, skips, faults, stops
        push(FUNC_TICK, 3'd0, 1'b1, 16'hFFFF);
        push(FUNC_CMD, 3'd7, 1'b1, 16'd0);
        push(FUNC_CMD, 3'd4, 1'b0, 16'hFFFF);
        tick(3'd4);
        tick(3'd5);
        tick(3'd1);
        tick(3'd3);
        tick(3'd2);
        tick(3'd6);
        tick(3'd4);
        tick(3'd4);
        // reversal while running, then a clockwise turn
        push(FUNC_CMD, 3'd4, 1'b1, 16'h0001);
        tick(3'd4);
        tick(3'd6);
        tick(3'd2);
        tick(3'd3);
        tick(3'd6);
        tick(3'd7);
        tick(3'd2);
        push(FUNC_CMD, 3'd0, 1'b0, 16'h8000);
        push(FUNC_CMD, 3'd0, 1'b1, 16'h5A5A);
        push(FUNC_CMD, 3'd2, 1'b0, 16'h0001);
        tick(3'd2);

        set_window(8'd1);
        random_run(60);
        set_window(8'd255);
        random_run(60);
        // below the running count, so the counter wraps first
        set_window(8'd3);
        random_run(60);
        set_window(8'd0);
        random_run(70);
        set_window(8'($urandom_range(2, 254)));
        random_run(60);

        set_window(8'($urandom_range(1, 255)));
        idle_on = 1'b0;
        // held step, the hold counter counts up
        spin_up();
        repeat (20) tick(hall_of(g_idx));
        random_run(50);

        drain();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("** hall_six_step_commutator: PASSED **");
        else
            $display("** hall_six_step_commutator: FAILED **");
        $finish;
    end

endmodule

### hall_six_step_commutator.f
+incdir+src
src/hsc_pkg.sv
src/hsc_cfg.sv
src/hsc_core.sv
src/hall_six_step_commutator.sv
bench/tb_hall_six_step_commutator.sv
